FILE: src/rvexe_pkg.sv
// ============================================================================
// rvexe_pkg
// Shared opcodes, cause codes and ALU helper for the RV32IM executor core.
// ============================================================================
package rvexe_pkg;

    localparam logic [31:0] RESET_PC = 32'h8000_0000;

    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_SYSTEM = 7'b1110011;

    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT    = 7'h20;

    localparam logic [0:0] REQ_LOAD  = 1'b0;
    localparam logic [0:0] REQ_STEP  = 1'b1;

    typedef logic [1:0] t_cause;
    localparam t_cause CAUSE_NONE    = 2'd0;
    localparam t_cause CAUSE_ECALL   = 2'd1;
    localparam t_cause CAUSE_EBREAK  = 2'd2;
    localparam t_cause CAUSE_ILLEGAL = 2'd3;

    // Base integer operation selected by funct3; alt picks sub and sra.
    function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
                                        input logic [31:0] a, input logic [31:0] b);
        logic [31:0] res;
        unique case (f3)
            3'd0: res = alt ? a - b : a + b;
            3'd1: res = a << b[4:0];
            3'd2: res = {31'd0, $signed(a) < $signed(b)};
            3'd3: res = {31'd0, a < b};
            3'd4: res = a ^ b;
            3'd5: res = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
            3'd6: res = a | b;
            default: res = a & b;
        endcase
        return res;
    endfunction

endpackage

FILE: src/rv32im_instruction_executor_core.sv
// ============================================================================
// rv32im_instruction_executor_core
// Multicycle RV32IM core with an internal word memory and register file.
//
// Input channel: a word with i_req_type low writes i_write_data to memory
// word i_word_address; with i_req_type high the core executes the one
// instruction at its pc. A word is taken when i_in_valid is high and
// o_in_stall is low. Every input word yields exactly one output word.
// A memory write or a step while halted goes straight to the result
// register. An instruction passes fetch, decode and execute, a multiply
// then a write-back step, divide and remainder a 32-step restoring divider
// and a write-back step, loads a read and a data step per byte and stores a
// write per byte, as memory moves one byte per access. All end in a commit.
// One instruction is in flight at a time; the core goes idle, ready for the
// next word, as the previous result enters the output register, even while
// that result still waits. When the receiver stalls, the output holds and
// the core parks its next result until the register frees.
// Reset clears the register file, the halt state and sets pc to
// 0x80000000. Memory contents are undefined until written.
// MEM_BYTES must be a power of two; addresses wrap within it.
// ============================================================================
module rv32im_instruction_executor_core
    import rvexe_pkg::*;
#(
    parameter int MEM_BYTES = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [12:0] i_word_address,
    input  logic [31:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_exec_pc,
    output logic [31:0] o_instr_word,
    output logic [4:0]  o_dest_index,
    output logic [31:0] o_dest_value,
    output logic        o_dest_written,
    output logic        o_store_done,
    output logic [31:0] o_store_address,
    output logic [31:0] o_store_value,
    output logic        o_halted,
    output logic [1:0]  o_stop_cause
);

    localparam int AW       = $clog2(MEM_BYTES);
    localparam int WW       = AW - 2;
    localparam int MemWords = MEM_BYTES / 4;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_FETCH  = 4'd1;
    localparam logic [3:0] ST_DECODE = 4'd2;
    localparam logic [3:0] ST_EXEC   = 4'd3;
    localparam logic [3:0] ST_MULWB  = 4'd4;
    localparam logic [3:0] ST_DIVRUN = 4'd5;
    localparam logic [3:0] ST_DIVWB  = 4'd6;
    localparam logic [3:0] ST_LDREQ  = 4'd7;
    localparam logic [3:0] ST_LDDAT  = 4'd8;
    localparam logic [3:0] ST_STBYTE = 4'd9;
    localparam logic [3:0] ST_COMMIT = 4'd10;
    localparam logic [3:0] ST_DONE   = 4'd11;

    logic [3:0]  r_state;
    logic [31:0] r_pc;
    logic        r_halt;
    t_cause      r_cause;

    // Instruction being worked on and its outcome.
    logic [31:0] r_ins;
    t_cause      r_stop;
    logic        r_wr;
    logic [31:0] r_val;
    logic [31:0] r_next;
    logic [31:0] r_addr;
    logic [31:0] r_sv;
    logic        r_st;
    logic [1:0]  r_bcnt;
    logic [1:0]  r_lane;
    logic [63:0] r_prod;

    // Divider.
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;
    logic [4:0]  r_dcnt;
    logic        r_neg_q;
    logic        r_neg_r;

    // Result waiting for the output register.
    logic [31:0] r_p_pc;
    logic [31:0] r_p_ins;
    logic [4:0]  r_p_didx;
    logic [31:0] r_p_dval;
    logic        r_p_dwr;
    logic        r_p_st;
    logic [31:0] r_p_saddr;
    logic [31:0] r_p_sval;

    // Output register.
    logic        r_o_valid;
    logic [31:0] r_o_pc;
    logic [31:0] r_o_ins;
    logic [4:0]  r_o_didx;
    logic [31:0] r_o_dval;
    logic        r_o_dwr;
    logic        r_o_st;
    logic [31:0] r_o_saddr;
    logic [31:0] r_o_sval;
    logic        r_o_halt;
    t_cause      r_o_cause;

    // ---------------------------------------------------------------------
    // Data memory: one write port with byte lanes, one registered read port.
    // ---------------------------------------------------------------------
    logic [31:0]   r_mem [MemWords];
    logic [31:0]   r_mem_q;
    logic          mem_we;
    logic [3:0]    mem_be;
    logic [WW-1:0] mem_widx;
    logic [31:0]   mem_wdata;
    logic [WW-1:0] mem_ridx;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            for (int l = 0; l < 4; l++) begin
                if (mem_be[l]) begin
                    r_mem[mem_widx][8*l +: 8] <= mem_wdata[8*l +: 8];
                end
            end
        end
        r_mem_q <= r_mem[mem_ridx];
    end

    // ---------------------------------------------------------------------
    // Register file: two registered read ports, valid bits stand in for the
    // reset clear, and x0 reads zero because it is never marked valid.
    // ---------------------------------------------------------------------
    logic [31:0] r_rf [32];
    logic [31:0] r_rf_vld;
    logic [31:0] r_rf_q1;
    logic [31:0] r_rf_q2;
    logic        r_v1;
    logic        r_v2;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic        rf_we;

    assign rs1 = r_mem_q[19:15];
    assign rs2 = r_mem_q[24:20];

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[r_ins[11:7]] <= r_val;
        end
        r_rf_q1 <= r_rf[rs1];
        r_rf_q2 <= r_rf[rs2];
        r_v1    <= r_rf_vld[rs1];
        r_v2    <= r_rf_vld[rs2];
    end

    // ---------------------------------------------------------------------
    // Decode and execute, valid in ST_EXEC.
    // ---------------------------------------------------------------------
    logic [31:0] a;
    logic [31:0] b;
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;

    assign a     = r_v1 ? r_rf_q1 : 32'd0;
    assign b     = r_v2 ? r_rf_q2 : 32'd0;
    assign op    = r_ins[6:0];
    assign f3    = r_ins[14:12];
    assign f7    = r_ins[31:25];
    assign imm_i = {{20{r_ins[31]}}, r_ins[31:20]};
    assign imm_s = {{20{r_ins[31]}}, r_ins[31:25], r_ins[11:7]};
    assign imm_b = {{19{r_ins[31]}}, r_ins[31], r_ins[7], r_ins[30:25], r_ins[11:8], 1'b0};
    assign imm_j = {{11{r_ins[31]}}, r_ins[31], r_ins[19:12], r_ins[20], r_ins[30:21], 1'b0};

    t_cause      e_stop;
    logic        e_wr;
    logic [31:0] e_val;
    logic [31:0] e_next;
    logic [31:0] e_addr;
    logic [31:0] e_sv;
    logic        e_st;
    logic [3:0]  e_go;
    logic        take;

    always_comb begin
        e_stop = CAUSE_NONE;
        e_wr   = 1'b0;
        e_val  = 32'd0;
        e_next = r_pc + 32'd4;
        e_addr = a + imm_i;
        e_sv   = b;
        e_st   = 1'b0;
        e_go   = ST_COMMIT;
        take   = 1'b0;
        unique case (op)
            OP_REG: begin
                if (f7 == F7_MULDIV) begin
                    e_wr = 1'b1;
                    if (!f3[2]) begin
                        e_go = ST_MULWB;
                    end else if (b == 32'd0) begin
                        // Division by zero: all ones, remainder is the dividend.
                        e_val = f3[1] ? a : 32'hFFFF_FFFF;
                    end else begin
                        e_go = ST_DIVRUN;
                    end
                end else if (f7 == F7_BASE) begin
                    e_wr  = 1'b1;
                    e_val = alu(f3, 1'b0, a, b);
                end else if (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5)) begin
                    e_wr  = 1'b1;
                    e_val = alu(f3, 1'b1, a, b);
                end else begin
                    e_stop = CAUSE_ILLEGAL;
                end
            end
            OP_IMM: begin
                if (f3 == 3'd1 && f7 != F7_BASE) begin
                    e_stop = CAUSE_ILLEGAL;
                end else if (f3 == 3'd5 && f7 != F7_BASE && f7 != F7_ALT) begin
                    e_stop = CAUSE_ILLEGAL;
                end else begin
                    e_wr  = 1'b1;
                    e_val = alu(f3, f3 == 3'd5 && f7 == F7_ALT, a, imm_i);
                end
            end
            OP_LOAD: begin
                if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) begin
                    e_stop = CAUSE_ILLEGAL;
                end else begin
                    e_wr = 1'b1;
                    e_go = ST_LDREQ;
                end
            end
            OP_STORE: begin
                e_addr = a + imm_s;
                if (f3 > 3'd2) begin
                    e_stop = CAUSE_ILLEGAL;
                end else begin
                    e_st = 1'b1;
                    e_go = ST_STBYTE;
                    if (f3 == 3'd0) begin
                        e_sv = {24'd0, b[7:0]};
                    end else if (f3 == 3'd1) begin
                        e_sv = {16'd0, b[15:0]};
                    end
                end
            end
            OP_BRANCH: begin
                unique case (f3)
                    3'd0: take = (a == b);
                    3'd1: take = (a != b);
                    3'd4: take = $signed(a) < $signed(b);
                    3'd5: take = $signed(a) >= $signed(b);
                    3'd6: take = (a < b);
                    3'd7: take = (a >= b);
                    default: e_stop = CAUSE_ILLEGAL;
                endcase
                if (take) begin
                    e_next = r_pc + imm_b;
                end
            end
            OP_LUI: begin
                e_wr  = 1'b1;
                e_val = {r_ins[31:12], 12'd0};
            end
            OP_AUIPC: begin
                e_wr  = 1'b1;
                e_val = r_pc + {r_ins[31:12], 12'd0};
            end
            OP_JALR: begin
                if (f3 != 3'd0) begin
                    e_stop = CAUSE_ILLEGAL;
                end else begin
                    // Target uses rs1 as read, before rd is written.
                    e_next = (a + imm_i) & ~32'd1;
                    e_wr   = 1'b1;
                    e_val  = r_pc + 32'd4;
                end
            end
            OP_JAL: begin
                e_next = r_pc + imm_j;
                e_wr   = 1'b1;
                e_val  = r_pc + 32'd4;
            end
            OP_SYSTEM: begin
                e_stop = (imm_i == 32'd0) ? CAUSE_ECALL : CAUSE_EBREAK;
            end
            default: begin
                e_stop = CAUSE_ILLEGAL;
            end
        endcase
    end

    // Multiplier operands, extended by one bit so one signed product covers
    // mulh, mulhsu and mulhu.
    logic signed [32:0] m_a;
    logic signed [32:0] m_b;
    logic signed [65:0] m_full;

    assign m_a    = {(f3 == 3'd1 || f3 == 3'd2) & a[31], a};
    assign m_b    = {(f3 == 3'd1) & b[31], b};
    assign m_full = m_a * m_b;

    // Divider step.
    logic [32:0] d_sh;
    logic [33:0] d_diff;
    logic        d_sign;

    assign d_sh   = {r_rem, r_quo[31]};
    assign d_diff = {1'b0, d_sh} - {2'b00, r_dvs};
    assign d_sign = !f3[0];

    // Byte access address: the memory offset is the low address bits.
    logic [31:0]   lb_addr;
    logic [1:0]    b_last;
    logic [7:0]    ld_byte;
    logic [31:0]   ld_word;
    logic [WW-1:0] req_widx;
    logic [31:0]   wa_ext;

    assign lb_addr  = r_addr + 32'(r_bcnt);
    assign b_last   = {f3[1], f3[1] | f3[0]};
    assign ld_byte  = r_mem_q[8*r_lane +: 8];
    assign ld_word  = r_val | (32'(ld_byte) << {r_bcnt, 3'b000});
    assign wa_ext   = 32'(i_word_address);
    assign req_widx = wa_ext[WW-1:0];

    logic in_take;
    logic out_free;

    assign in_take  = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_o_valid || !i_out_stall;

    // Memory port selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_be    = 4'h0;
        mem_widx  = req_widx;
        mem_wdata = i_write_data;
        mem_ridx  = r_pc[AW-1:2];
        if (in_take && i_req_type == REQ_LOAD) begin
            mem_we = 1'b1;
            mem_be = 4'hF;
        end else if (r_state == ST_STBYTE) begin
            mem_we    = 1'b1;
            mem_be    = 4'(1) << lb_addr[1:0];
            mem_widx  = lb_addr[AW-1:2];
            mem_wdata = {4{r_sv[8*r_bcnt +: 8]}};
        end
        if (r_state == ST_LDREQ) begin
            mem_ridx = lb_addr[AW-1:2];
        end
    end

    assign rf_we = (r_state == ST_COMMIT) && (r_stop == CAUSE_NONE) && r_wr &&
                   (r_ins[11:7] != 5'd0);

    // ---------------------------------------------------------------------
    // Control and datapath registers.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pc      <= RESET_PC;
            r_halt    <= 1'b0;
            r_cause   <= CAUSE_NONE;
            r_rf_vld  <= 32'd0;
            r_o_valid <= 1'b0;
        end else begin
            // The parked result moves in as soon as the output register frees.
            if (r_state == ST_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_take) begin
                        r_p_pc    <= (i_req_type == REQ_STEP && r_halt) ? r_pc : 32'd0;
                        r_p_ins   <= 32'd0;
                        r_p_didx  <= 5'd0;
                        r_p_dval  <= 32'd0;
                        r_p_dwr   <= 1'b0;
                        r_p_st    <= 1'b0;
                        r_p_saddr <= 32'd0;
                        r_p_sval  <= 32'd0;
                        if (i_req_type == REQ_LOAD) begin
                            r_state <= ST_DONE;
                        end else if (r_halt) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_FETCH;
                        end
                    end
                end
                ST_FETCH: begin
                    r_state <= ST_DECODE;
                end
                ST_DECODE: begin
                    r_ins   <= r_mem_q;
                    r_state <= ST_EXEC;
                end
                ST_EXEC: begin
                    r_stop  <= e_stop;
                    r_wr    <= e_wr;
                    r_val   <= e_val;
                    r_next  <= e_next;
                    r_addr  <= e_addr;
                    r_sv    <= e_sv;
                    r_st    <= e_st;
                    r_bcnt  <= 2'd0;
                    r_prod  <= 64'(m_full);
                    r_rem   <= 32'd0;
                    r_quo   <= (d_sign && a[31]) ? -a : a;
                    r_dvs   <= (d_sign && b[31]) ? -b : b;
                    r_neg_q <= d_sign && (a[31] ^ b[31]);
                    r_neg_r <= d_sign && a[31];
                    r_dcnt  <= 5'd31;
                    r_state <= e_go;
                end
                ST_MULWB: begin
                    r_val   <= (f3 == 3'd0) ? r_prod[31:0] : r_prod[63:32];
                    r_state <= ST_COMMIT;
                end
                ST_DIVRUN: begin
                    if (!d_diff[33]) begin
                        r_rem <= d_diff[31:0];
                    end else begin
                        r_rem <= d_sh[31:0];
                    end
                    r_quo  <= {r_quo[30:0], !d_diff[33]};
                    r_dcnt <= r_dcnt - 5'd1;
                    if (r_dcnt == 5'd0) begin
                        r_state <= ST_DIVWB;
                    end
                end
                ST_DIVWB: begin
                    if (f3[1]) begin
                        r_val <= r_neg_r ? -r_rem : r_rem;
                    end else begin
                        r_val <= r_neg_q ? -r_quo : r_quo;
                    end
                    r_state <= ST_COMMIT;
                end
                ST_LDREQ: begin
                    r_lane  <= lb_addr[1:0];
                    r_state <= ST_LDDAT;
                end
                ST_LDDAT: begin
                    if (r_bcnt == b_last) begin
                        if (f3 == 3'd0) begin
                            r_val <= {{24{ld_word[7]}}, ld_word[7:0]};
                        end else if (f3 == 3'd1) begin
                            r_val <= {{16{ld_word[15]}}, ld_word[15:0]};
                        end else begin
                            r_val <= ld_word;
                        end
                        r_state <= ST_COMMIT;
                    end else begin
                        r_val   <= ld_word;
                        r_bcnt  <= r_bcnt + 2'd1;
                        r_state <= ST_LDREQ;
                    end
                end
                ST_STBYTE: begin
                    if (r_bcnt == b_last) begin
                        r_state <= ST_COMMIT;
                    end else begin
                        r_bcnt <= r_bcnt + 2'd1;
                    end
                end
                ST_COMMIT: begin
                    r_p_pc    <= r_pc;
                    r_p_ins   <= r_ins;
                    r_p_didx  <= rf_we ? r_ins[11:7] : 5'd0;
                    r_p_dval  <= rf_we ? r_val : 32'd0;
                    r_p_dwr   <= rf_we;
                    r_p_st    <= r_st;
                    r_p_saddr <= r_st ? r_addr : 32'd0;
                    r_p_sval  <= r_st ? r_sv : 32'd0;
                    if (r_stop != CAUSE_NONE) begin
                        r_halt  <= 1'b1;
                        r_cause <= r_stop;
                    end else begin
                        r_pc <= r_next;
                        if (rf_we) begin
                            r_rf_vld[r_ins[11:7]] <= 1'b1;
                        end
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Output payload loads as the parked result moves in.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_o_pc    <= r_p_pc;
            r_o_ins   <= r_p_ins;
            r_o_didx  <= r_p_didx;
            r_o_dval  <= r_p_dval;
            r_o_dwr   <= r_p_dwr;
            r_o_st    <= r_p_st;
            r_o_saddr <= r_p_saddr;
            r_o_sval  <= r_p_sval;
            r_o_halt  <= r_halt;
            r_o_cause <= r_cause;
        end
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_o_valid;
    assign o_exec_pc       = r_o_pc;
    assign o_instr_word    = r_o_ins;
    assign o_dest_index    = r_o_didx;
    assign o_dest_value    = r_o_dval;
    assign o_dest_written  = r_o_dwr;
    assign o_store_done    = r_o_st;
    assign o_store_address = r_o_saddr;
    assign o_store_value   = r_o_sval;
    assign o_halted        = r_o_halt;
    assign o_stop_cause    = r_o_cause;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    a_halt_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |-> (r_cause != CAUSE_NONE))
        else $error("core halted without a stop cause");

    a_pc_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> $stable(r_pc))
        else $error("pc moved while halted");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVRUN && r_dcnt == 5'd0) |=> (r_state == ST_DIVWB))
        else $error("divider did not finish after its last step");

    a_x0_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_rf_vld[0])
        else $error("register x0 was written");

endmodule

FILE: verif/rv32im_instruction_executor_core_tb.sv
// ============================================================================
// rv32im_instruction_executor_core_tb
// Self-checking bench for the RV32IM executor core. A directed program covers
// reset state, divide corner cases, mulhu, stores, loads, jalr with rd equal to
// rs1 and the address extremes. Random instructions follow, each one written
// into memory at the pc just before it is stepped. Every result word is
// compared field by field against a behavioral model of the core or the
// values in its directed row. The run halts the core, then steps and writes to it.
// ============================================================================
module rv32im_instruction_executor_core_tb;
    import rvexe_pkg::*;

    localparam int MEMB  = 32768;
    localparam int LIMIT = 400000;

    // Function codes used by the model and the instruction generator.
    localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
    localparam logic [2:0] F3_MUL = 3'd0, F3_MULH = 3'd1, F3_MULHSU = 3'd2;
    localparam logic [2:0] F3_MULHU = 3'd3, F3_DIV = 3'd4, F3_DIVU = 3'd5;
    localparam logic [2:0] F3_REM = 3'd6, F3_REMU = 3'd7;
    localparam logic [2:0] F3_LB = 3'd0, F3_LH = 3'd1, F3_LW = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4, F3_LHU = 3'd5;
    localparam logic [2:0] F3_SB = 3'd0, F3_SH = 3'd1, F3_SW = 3'd2;
    localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4;
    localparam logic [2:0] F3_BGE = 3'd5, F3_BLTU = 3'd6, F3_BGEU = 3'd7;
    localparam logic [2:0] F3_JALR = 3'd0;

    // Encodings that no instruction uses, for the illegal stop.
    localparam logic [6:0] OP_UNUSED = 7'b1111111;
    localparam logic [6:0] F7_UNUSED = 7'h02;

    typedef struct packed {
        logic [31:0] pc;
        logic [31:0] ins;
        logic [4:0]  rd;
        logic [31:0] val;
        logic        wr;
        logic        sd;
        logic [31:0] sa;
        logic [31:0] sv;
        logic        h;
        t_cause      c;
    } result_t;

    // One row of the directed program. When typed is set, the expected
    // pc, instruction and register write are given right in the row.
    typedef struct packed {
        logic        req;
        logic [12:0] wa;
        logic [31:0] wd;
        logic        typed;
        logic [31:0] e_pc;
        logic [31:0] e_ins;
        logic [4:0]  e_rd;
        logic [31:0] e_val;
        logic        e_wr;
    } row_t;

    localparam int NROWS = 23;
    localparam row_t DIR_ROWS [NROWS] = '{
        // lui x1, 0x80000
        '{REQ_LOAD, 13'd0, 32'h800000B7, 1'b1, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0},
        '{REQ_STEP, 13'd0, 32'h0, 1'b1, 32'h80000000, 32'h800000B7, 5'd1, 32'h80000000, 1'b1},
        // addi x2, x0, -1
        '{REQ_LOAD, 13'd1, 32'hFFF00113, 1'b1, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0},
        '{REQ_STEP, 13'd0, 32'h0, 1'b1, 32'h80000004, 32'hFFF00113, 5'd2, 32'hFFFFFFFF, 1'b1},
        // div x3, x1, x2: most negative over minus one
        '{REQ_LOAD, 13'd2, 32'h0220C1B3, 1'b1, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0},
        '{REQ_STEP, 13'd0, 32'h0, 1'b1, 32'h80000008, 32'h0220C1B3, 5'd3, 32'h80000000, 1'b1},
        // rem x4, x1, x2
        '{REQ_LOAD, 13'd3, 32'h0220E233, 1'b1, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0},
        '{REQ_STEP, 13'd0, 32'h0, 1'b1, 32'h8000000C, 32'h0220E233, 5'd4, 32'h0, 1'b1},
        // divu x5, x1, x0: zero divisor
        '{REQ_LOAD, 13'd4, 32'h0200D2B3, 1'b1, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0},
        '{REQ_STEP, 13'd0, 32'h0, 1'b1, 32'h80000010, 32'h0200D2B3, 5'd5, 32'hFFFFFFFF, 1'b1},
        // remu x6, x1, x0: zero divisor returns the dividend
        '{REQ_LOAD, 13'd5, 32'h0200F333, 1'b1, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0},
        '{REQ_STEP, 13'd0, 32'h0, 1'b1, 32'h80000014, 32'h0200F333, 5'd6, 32'h80000000, 1'b1},
        // mulhu x7, x2, x2
        '{REQ_LOAD, 13'd6, 32'h022133B3, 1'b1, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0},
        '{REQ_STEP, 13'd0, 32'h0, 1'b1, 32'h80000018, 32'h022133B3, 5'd7, 32'hFFFFFFFE, 1'b1},
        // sw x2, 0(x1) overwrites word zero
        '{REQ_LOAD, 13'd7, 32'h0020A023, 1'b1, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0},
        '{REQ_STEP, 13'd0, 32'h0, 1'b0, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0},
        // lb x8, 3(x1) reads back a stored byte
        '{REQ_LOAD, 13'd8, 32'h00308403, 1'b1, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0},
        '{REQ_STEP, 13'd0, 32'h0, 1'b0, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0},
        // jalr x1, 41(x1): odd target, rd equal to rs1
        '{REQ_LOAD, 13'd9, 32'h029080E7, 1'b1, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0},
        '{REQ_STEP, 13'd0, 32'h0, 1'b0, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0},
        // srai x9, x2, 31
        '{REQ_LOAD, 13'd10, 32'h41F15493, 1'b1, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0},
        '{REQ_STEP, 13'd0, 32'h0, 1'b0, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0},
        // Highest word address with all ones.
        '{REQ_LOAD, 13'h1FFF, 32'hFFFFFFFF, 1'b1, 32'h0, 32'h0, 5'd0, 32'h0, 1'b0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_req_type;
    logic [12:0] i_word_address;
    logic [31:0] i_write_data;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_exec_pc;
    logic [31:0] o_instr_word;
    logic [4:0]  o_dest_index;
    logic [31:0] o_dest_value;
    logic        o_dest_written;
    logic        o_store_done;
    logic [31:0] o_store_address;
    logic [31:0] o_store_value;
    logic        o_halted;
    logic [1:0]  o_stop_cause;

    rv32im_instruction_executor_core #(.MEM_BYTES(MEMB)) uut (.*);

    // Model state of the core.
    logic [7:0]  mem_img [MEMB];
    bit          mem_set [MEMB];
    logic [31:0] core_regs [32];
    logic [31:0] core_pc;
    logic        core_halt;
    t_cause      core_cause;

    result_t retire_queue [$];
    int          mismatches = 0;
    int          words_sent = 0;
    int          results_seen = 0;
    int          cycle_cnt = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned moff(input logic [31:0] a);
        return int'((a - RESET_PC) & (MEMB - 1));
    endfunction

    function automatic logic [31:0] mem_get(input logic [31:0] a, input int n);
        logic [31:0] v;
        v = '0;
        for (int i = 0; i < n; i++)
            v |= {24'd0, mem_img[moff(a + i)]} << (8 * i);
        return v;
    endfunction

    function automatic void mem_put(input logic [31:0] a, input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) begin
            mem_img[moff(a + i)] = v[8*i +: 8];
            mem_set[moff(a + i)] = 1'b1;
        end
    endfunction

    function automatic logic [31:0] base_op(input logic [2:0] f3, input logic alt,
                                            input logic [31:0] a, input logic [31:0] b);
        case (f3)
            F3_ADD:  return alt ? a - b : a + b;
            F3_SLL:  return a << b[4:0];
            F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
            F3_XOR:  return a ^ b;
            F3_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
            F3_OR:   return a | b;
            default: return a & b;
        endcase
    endfunction

    function automatic logic [31:0] mul_div(input logic [2:0] f3,
                                            input logic [31:0] a, input logic [31:0] b);
        logic signed [63:0] sa, sb, ub, p;
        logic [63:0] pu;
        logic ovf;
        sa  = {{32{a[31]}}, a};
        sb  = {{32{b[31]}}, b};
        ub  = {32'd0, b};
        pu  = {32'd0, a} * {32'd0, b};
        ovf = (a == 32'h80000000) && (b == 32'hFFFFFFFF);
        case (f3)
            F3_MUL:    return a * b;
            F3_MULH:   begin p = sa * sb; return p[63:32]; end
            F3_MULHSU: begin p = sa * ub; return p[63:32]; end
            F3_MULHU:  return pu[63:32];
            F3_DIV:    return (b == 0) ? 32'hFFFFFFFF : ovf ? 32'h80000000
                              : 32'($signed(a) / $signed(b));
            F3_DIVU:   return (b == 0) ? 32'hFFFFFFFF : a / b;
            F3_REM:    return (b == 0) ? a : ovf ? 32'd0 : 32'($signed(a) % $signed(b));
            default:   return (b == 0) ? a : a % b;
        endcase
    endfunction

    // Applies one input word to the model state and returns its result word.
    function automatic result_t predict_retire(input logic req, input logic [12:0] wa,
                                               input logic [31:0] wd);
        result_t r;
        logic [31:0] ins, a, b, imm_i, imm, nxt, val, addr, sv;
        logic [6:0] op, f7;
        logic [4:0] rd;
        logic [2:0] f3;
        logic wr, take;
        t_cause stop;
        int n;
        r = '0;
        if (req == REQ_LOAD) begin
            mem_put(RESET_PC + {17'd0, wa, 2'b00}, wd, 4);
        end else if (core_halt) begin
            r.pc = core_pc;
        end else begin
            ins   = mem_get(core_pc & ~32'd3, 4);
            op    = ins[6:0];
            rd    = ins[11:7];
            f3    = ins[14:12];
            f7    = ins[31:25];
            a     = core_regs[ins[19:15]];
            b     = core_regs[ins[24:20]];
            imm_i = {{20{ins[31]}}, ins[31:20]};
            nxt   = core_pc + 4;
            val   = '0;
            wr    = 1'b0;
            stop  = CAUSE_NONE;
            r.pc  = core_pc;
            r.ins = ins;
            case (op)
                OP_REG: begin
                    if (f7 == F7_MULDIV) begin
                        val = mul_div(f3, a, b); wr = 1'b1;
                    end else if (f7 == F7_BASE) begin
                        val = base_op(f3, 1'b0, a, b); wr = 1'b1;
                    end else if (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR)) begin
                        val = base_op(f3, 1'b1, a, b); wr = 1'b1;
                    end else begin
                        stop = CAUSE_ILLEGAL;
                    end
                end
                OP_IMM: begin
                    if (f3 == F3_SLL && f7 != F7_BASE)
                        stop = CAUSE_ILLEGAL;
                    else if (f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT)
                        stop = CAUSE_ILLEGAL;
                    else begin
                        val = base_op(f3, f3 == F3_SR && f7 == F7_ALT, a, imm_i);
                        wr = 1'b1;
                    end
                end
                OP_LOAD: begin
                    addr = a + imm_i;
                    wr = 1'b1;
                    case (f3)
                        F3_LB:  begin n = mem_get(addr, 1); val = {{24{n[7]}}, n[7:0]}; end
                        F3_LH:  begin n = mem_get(addr, 2); val = {{16{n[15]}}, n[15:0]}; end
                        F3_LW:  val = mem_get(addr, 4);
                        F3_LBU: val = mem_get(addr, 1);
                        F3_LHU: val = mem_get(addr, 2);
                        default: begin wr = 1'b0; stop = CAUSE_ILLEGAL; end
                    endcase
                end
                OP_STORE: begin
                    if (f3 > F3_SW) begin
                        stop = CAUSE_ILLEGAL;
                    end else begin
                        n = 1 << f3;
                        sv = (f3 == F3_SW) ? b : (f3 == F3_SH) ? {16'd0, b[15:0]}
                                                              : {24'd0, b[7:0]};
                        addr = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
                        mem_put(addr, sv, n);
                        r.sd = 1'b1; r.sa = addr; r.sv = sv;
                    end
                end
                OP_BRANCH: begin
                    imm = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
                    case (f3)
                        F3_BEQ:  take = (a == b);
                        F3_BNE:  take = (a != b);
                        F3_BLT:  take = ($signed(a) < $signed(b));
                        F3_BGE:  take = ($signed(a) >= $signed(b));
                        F3_BLTU: take = (a < b);
                        F3_BGEU: take = (a >= b);
                        default: begin take = 1'b0; stop = CAUSE_ILLEGAL; end
                    endcase
                    if (take) nxt = core_pc + imm;
                end
                OP_LUI:   begin val = {ins[31:12], 12'd0}; wr = 1'b1; end
                OP_AUIPC: begin val = core_pc + {ins[31:12], 12'd0}; wr = 1'b1; end
                OP_JALR: begin
                    if (f3 != F3_JALR) begin
                        stop = CAUSE_ILLEGAL;
                    end else begin
                        nxt = (a + imm_i) & ~32'd1;
                        val = core_pc + 4; wr = 1'b1;
                    end
                end
                OP_JAL: begin
                    imm = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
                    nxt = core_pc + imm;
                    val = core_pc + 4; wr = 1'b1;
                end
                OP_SYSTEM: stop = (imm_i == 0) ? CAUSE_ECALL : CAUSE_EBREAK;
                default:   stop = CAUSE_ILLEGAL;
            endcase
            if (stop != CAUSE_NONE) begin
                core_halt  = 1'b1;
                core_cause = stop;
            end else begin
                if (wr && rd != 0) begin
                    core_regs[rd] = val;
                    r.rd = rd; r.val = val; r.wr = 1'b1;
                end
                core_pc = nxt;
            end
        end
        r.h = core_halt;
        r.c = core_cause;
        return r;
    endfunction

    // Offers one word and returns at the falling edge after it was taken.
    task automatic drive_word(input logic req, input logic [12:0] wa, input logic [31:0] wd);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_word_address <= wa;
        i_write_data   <= wd;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic issue_word(input logic req, input logic [12:0] wa, input logic [31:0] wd);
        retire_queue.push_back(predict_retire(req, wa, wd));
        drive_word(req, wa, wd);
    endtask

    // Builds one legal, non-stopping instruction from random fields, makes
    // sure every byte it will load has been written, places it at the pc and
    // steps the core.
    task automatic random_instruction();
        logic [31:0] ins, rnd, addr;
        logic [4:0] rd, rs1, rs2;
        logic [6:0] f7;
        logic [2:0] f3;
        int nb, o;
        if ($urandom_range(0, 7) == 0)
            issue_word(REQ_LOAD, 13'($urandom), $urandom);
        rd  = 5'($urandom);
        rs1 = 5'($urandom);
        rs2 = 5'($urandom);
        rnd = $urandom;
        f3  = 3'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                f7 = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
                if (f7 == F7_ALT) f3 = $urandom_range(0, 1) ? F3_ADD : F3_SR;
                ins = {f7, rs2, rs1, f3, rd, OP_REG};
            end
            1: ins = {F7_MULDIV, rs2, rs1, f3, rd, OP_REG};
            2: begin
                if (f3 == F3_SLL) rnd[11:5] = F7_BASE;
                if (f3 == F3_SR) rnd[11:5] = rnd[12] ? F7_ALT : F7_BASE;
                ins = {rnd[11:0], rs1, f3, rd, OP_IMM};
            end
            3: begin
                case ($urandom_range(0, 4))
                    0: begin f3 = F3_LB; nb = 1; end
                    1: begin f3 = F3_LH; nb = 2; end
                    2: begin f3 = F3_LW; nb = 4; end
                    3: begin f3 = F3_LBU; nb = 1; end
                    default: begin f3 = F3_LHU; nb = 2; end
                endcase
                addr = core_regs[rs1] + {{20{rnd[11]}}, rnd[11:0]};
                for (int i = 0; i < nb; i++) begin
                    o = moff(addr + i);
                    if (!mem_set[o]) issue_word(REQ_LOAD, 13'(o >> 2), $urandom);
                end
                ins = {rnd[11:0], rs1, f3, rd, OP_LOAD};
            end
            4: begin
                f3 = 3'($urandom_range(F3_SB, F3_SW));
                ins = {rnd[11:5], rs2, rs1, f3, rnd[4:0], OP_STORE};
            end
            5: begin
                while (!(f3 inside {F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU}))
                    f3 = 3'($urandom);
                ins = {rnd[31], rnd[29:24], rs2, rs1, f3, rnd[4:1], rnd[30], OP_BRANCH};
            end
            6: ins = {rnd[31:12], rd, OP_LUI};
            7: ins = {rnd[31:12], rd, OP_AUIPC};
            8: ins = {rnd[31:12], rd, OP_JAL};
            default: ins = {rnd[11:0], rs1, F3_JALR, rd, OP_JALR};
        endcase
        issue_word(REQ_LOAD, 13'(moff(core_pc) >> 2), ins);
        issue_word(REQ_STEP, 13'($urandom), $urandom);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 30)
            $display("tb mismatch at cycle %0d: %s got %h expected %h",
                     cycle_cnt, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // Receiver: random stalls, plus a long hold-off when hold_cnt is loaded.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cnt > 0) begin
                i_out_stall <= 1'b1;
                hold_cnt--;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Each taken result word is checked against the oldest expectation.
    always @(posedge i_clk) begin
        result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (retire_queue.size() == 0) begin
                report_mismatch("result with nothing expected", o_exec_pc, 32'd0);
            end else begin
                want = retire_queue.pop_front();
                results_seen++;
                check_field("exec_pc", o_exec_pc, want.pc);
                check_field("instr_word", o_instr_word, want.ins);
                check_field("dest_index", {27'd0, o_dest_index}, {27'd0, want.rd});
                check_field("dest_value", o_dest_value, want.val);
                check_field("dest_written", {31'd0, o_dest_written}, {31'd0, want.wr});
                check_field("store_done", {31'd0, o_store_done}, {31'd0, want.sd});
                check_field("store_address", o_store_address, want.sa);
                check_field("store_value", o_store_value, want.sv);
                check_field("halted", {31'd0, o_halted}, {31'd0, want.h});
                check_field("stop_cause", {30'd0, o_stop_cause}, {30'd0, want.c});
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        result_t want;
        row_t row;
        logic [31:0] stop_ins;
        int phase_start;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_req_type     = 1'b0;
        i_word_address = '0;
        i_write_data   = '0;
        for (int i = 0; i < 32; i++) core_regs[i] = '0;
        for (int i = 0; i < MEMB; i++) begin
            mem_img[i] = '0;
            mem_set[i] = 1'b0;
        end
        core_pc    = RESET_PC;
        core_halt  = 1'b0;
        core_cause = CAUSE_NONE;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed program with no idling on either side.
        for (int k = 0; k < NROWS; k++) begin
            row  = DIR_ROWS[k];
            want = predict_retire(row.req, row.wa, row.wd);
            if (row.typed) begin
                want = '0;
                want.pc = row.e_pc;
                want.ins = row.e_ins;
                want.rd = row.e_rd;
                want.val = row.e_val;
                want.wr = row.e_wr;
            end
            retire_queue.push_back(want);
            drive_word(row.req, row.wa, row.wd);
        end

        // Random phases. The first opens with a long receiver hold-off while
        // the sender keeps offering words, so the core backs up and stalls.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; hold_cnt = 300; end
                1: begin send_idle_pct = 78; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 78; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            phase_start = words_sent;
            while (words_sent - phase_start < 95) random_instruction();
        end

        // Stop the core with a random cause, then step it and write to it.
        case ($urandom_range(0, 3))
            0: stop_ins = {25'd0, OP_SYSTEM};
            1: stop_ins = {12'($urandom_range(1, 4095)), 13'd0, OP_SYSTEM};
            2: stop_ins = {25'($urandom), OP_UNUSED};
            default: stop_ins = {F7_UNUSED, 18'($urandom), OP_REG};
        endcase
        issue_word(REQ_LOAD, 13'(moff(core_pc) >> 2), stop_ins);
        issue_word(REQ_STEP, 13'($urandom), $urandom);
        issue_word(REQ_STEP, 13'($urandom), $urandom);
        issue_word(REQ_LOAD, 13'($urandom), $urandom);
        issue_word(REQ_STEP, 13'($urandom), $urandom);
        i_in_valid <= 1'b0;

        while (retire_queue.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("tb summary: %0d words sent, %0d results checked over four idle patterns,",
                 words_sent, results_seen);
        $display("tb summary: ended halted with cause %0d, %0d mismatches",
                 core_cause, mismatches);
        if (mismatches == 0 && retire_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
